// ===== design/sem_pkg.sv =====
package sem_pkg;

   localparam int MAX_WIDTH_DEFAULT = 2048;
   localparam int JOB_QUEUE_DEPTH   = 4;

   localparam int CFG_WIDTH_W  = 12;
   localparam int CFG_HEIGHT_W = 16;
   localparam int CSR_DATA_W   = 16;

   localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
   localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

   localparam logic [7:0] PIX_MAX = 8'd255;

   // bit positions in a job's result mask, in emission order
   localparam int SLOT_CENTER      = 0;
   localparam int SLOT_ROW_END     = 1;
   localparam int SLOT_LAST_CENTER = 2;
   localparam int SLOT_LAST_END    = 3;
   localparam int SLOT_COUNT       = 4;

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // blue in the low byte, red in the high byte
   typedef logic [23:0] pixel_type;

   typedef struct packed {
      logic       frame_start;
      logic [7:0] blue_in;
      logic [7:0] green_in;
      logic [7:0] red_in;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] blue_out;
      logic [7:0] green_out;
      logic [7:0] red_out;
      logic       frame_last;
   } rsp_payload_type;

   typedef struct packed {
      logic [SLOT_COUNT-1:0] mask;
      pixel_type             value;
   } job_type;

   typedef struct packed {
      logic s1_busy;
      logic s2_busy;
   } front_status_type;

endpackage

// ===== design/sobel_edge_magnitude_3x3.sv =====
// streaming 3x3 sobel edge magnitude on 24-bit bgr pixels in raster order. each channel
// gives (|gx|+|gy|)/4 saturated at 255, zero on the image border, one result per input
// pixel delayed by one row and one column, so a frame of w*h pixels gives w*h results
// and the last one carries frame_last. pixels are taken one per clock while req_full is
// low; the single result port moves one result per clock while the receiver pops, so the
// last pixel of each row (two results) and each pixel but the first of the last row
// (two results, four at its end) hold the input back for the extra cycles. the line
// buffers are one one-read one-write memory of max_width words, read at transfer and
// written back in the next cycle; they need no clearing after reset since a complete
// frame writes every word it reads. the user must write image_width and image_height
// only while the block is idle; it is not enforced
module sobel_edge_magnitude_3x3
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
   parameter int JQ_DEPTH  = JOB_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   // pixel input queue side
   input  logic                  req_push,
   output logic                  req_full,
   input  req_payload_type       req_data,
   // result queue side
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_payload_type       rsp_data,
   // register writes
   input  logic                  csr_write,
   input  logic [0:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW = $clog2(JQ_DEPTH + 1);

   // configuration registers
   logic [CFG_WIDTH_W-1:0]  width_ff;
   logic [CFG_HEIGHT_W-1:0] height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[CFG_WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[CFG_HEIGHT_W-1:0];
         endcase
      end
   end

   logic             in_xfer;
   logic             job_valid, job_pop, head_valid;
   job_type          job, head_job;
   front_status_type front_status;
   logic [CW-1:0]    q_count;
   logic [CW:0]      credits_used;

   // every pixel in the front pipe may become a job, so it holds a queue slot
   assign credits_used = (CW+1)'(q_count) + (CW+1)'(front_status.s1_busy) +
                         (CW+1)'(front_status.s2_busy);
   assign req_full     = credits_used >= (CW+1)'(JQ_DEPTH);
   assign in_xfer      = req_push && !req_full;

   // front: position counters, line buffers, window and kernel
   sem_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (in_xfer),
      .req        (req_data),
      .cfg_width  (width_ff),
      .cfg_height (height_ff),
      .job_valid  (job_valid),
      .job        (job),
      .status     (front_status)
   );

   // short queue of jobs, each naming the one to four results of a pixel
   sem_job_queue #(
      .DEPTH (JQ_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_valid),
      .push_job   (job),
      .pop        (job_pop),
      .head_valid (head_valid),
      .head_job   (head_job),
      .count      (q_count)
   );

   // back: expands jobs into single results behind an output register
   sem_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (head_valid),
      .job       (head_job),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // the credit scheme keeps the job queue from overflowing
   a_queue_no_overflow : assert property (@(posedge clock) disable iff (reset)
      !(job_valid && (q_count == CW'(JQ_DEPTH))))
      else $error("job queue written while full");

   a_credit_bound : assert property (@(posedge clock) disable iff (reset)
      credits_used <= (CW+1)'(JQ_DEPTH))
      else $error("front pipe holds more pixels than queue slots");

   // the frame's final result is a border pixel
   a_last_is_zero : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.frame_last) |->
         (rsp_data.blue_out == 8'd0 && rsp_data.green_out == 8'd0 &&
          rsp_data.red_out == 8'd0))
      else $error("frame_last result with nonzero channels");

   // a job is never taken from an empty queue
   a_pop_has_job : assert property (@(posedge clock) disable iff (reset)
      job_pop |-> (q_count != '0))
      else $error("job taken from empty queue");

endmodule

// ===== design/sem_front.sv =====
module sem_front
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  req_payload_type         req,
   input  logic [CFG_WIDTH_W-1:0]  cfg_width,
   input  logic [CFG_HEIGHT_W-1:0] cfg_height,
   output logic                    job_valid,
   output job_type                 job,
   output front_status_type        status
);

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int EW = (CFG_WIDTH_W > $clog2(MAX_WIDTH + 1)) ?
                       CFG_WIDTH_W : $clog2(MAX_WIDTH + 1);

   function automatic logic [7:0] sobel_chan(input logic [7:0] t0, input logic [7:0] m0,
                                             input logic [7:0] b0, input logic [7:0] t1,
                                             input logic [7:0] b1, input logic [7:0] t2,
                                             input logic [7:0] m2, input logic [7:0] b2);
      logic [9:0]         sy_b, sy_t, sx_r, sx_l;
      logic signed [11:0] gy, gx;
      logic [11:0]        ay, ax, mag;
      logic [9:0]         quarter;
      sy_b = {2'b00, b0} + {1'b0, b1, 1'b0} + {2'b00, b2};
      sy_t = {2'b00, t0} + {1'b0, t1, 1'b0} + {2'b00, t2};
      sx_r = {2'b00, t2} + {1'b0, m2, 1'b0} + {2'b00, b2};
      sx_l = {2'b00, t0} + {1'b0, m0, 1'b0} + {2'b00, b0};
      gy = $signed({2'b00, sy_b}) - $signed({2'b00, sy_t});
      gx = $signed({2'b00, sx_r}) - $signed({2'b00, sx_l});
      ay = gy[11] ? 12'(-gy) : 12'(gy);
      ax = gx[11] ? 12'(-gx) : 12'(gx);
      mag = ay + ax;
      quarter = mag[11:2];
      return (quarter > {2'b00, PIX_MAX}) ? PIX_MAX : quarter[7:0];
   endfunction

   // stage 0: position, classification, line buffer read
   logic [XW-1:0]           col_ff, col_in;
   logic [CFG_HEIGHT_W-1:0] row_ff, row_in;
   logic [XW-1:0]           x_cur;
   logic [CFG_HEIGHT_W-1:0] y_cur;
   logic [EW-1:0]           w_raw, w_eff, x_ext;
   logic [CFG_HEIGHT_W-1:0] h_eff;
   logic                    row_end, last_row, x_ge1, y_ge1, interior;
   logic [SLOT_COUNT-1:0]   mask0;
   pixel_type               pix0;

   assign x_cur = req.frame_start ? '0 : col_ff;
   assign y_cur = req.frame_start ? '0 : row_ff;
   assign w_raw = EW'(cfg_width);
   assign x_ext = EW'(x_cur);
   assign pix0  = {req.red_in, req.green_in, req.blue_in};

   always_comb begin
      if (w_raw < EW'(3)) begin
         w_eff = EW'(3);
      end else if (w_raw > EW'(MAX_WIDTH)) begin
         w_eff = EW'(MAX_WIDTH);
      end else begin
         w_eff = w_raw;
      end
      h_eff = (cfg_height < CFG_HEIGHT_W'(3)) ? CFG_HEIGHT_W'(3) : cfg_height;
      row_end  = x_ext >= (w_eff - EW'(1));
      last_row = y_cur >= (h_eff - CFG_HEIGHT_W'(1));
      x_ge1    = x_cur != '0;
      y_ge1    = y_cur != '0;
      interior = (y_cur >= CFG_HEIGHT_W'(2)) && (x_cur >= XW'(2)) &&
                 (x_ext <= (w_eff - EW'(1))) && (y_cur <= (h_eff - CFG_HEIGHT_W'(1)));
      mask0 = '0;
      mask0[SLOT_CENTER]      = y_ge1 && x_ge1;
      mask0[SLOT_ROW_END]     = y_ge1 && row_end;
      mask0[SLOT_LAST_CENTER] = y_ge1 && last_row && x_ge1;
      mask0[SLOT_LAST_END]    = y_ge1 && last_row && row_end;
      if (row_end) begin
         col_in = '0;
         row_in = last_row ? '0 : y_cur + CFG_HEIGHT_W'(1);
      end else begin
         col_in = x_cur + XW'(1);
         row_in = y_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage 1 registers
   logic                  s1_v_ff, fwd_ff;
   logic [XW-1:0]         s1_x_ff;
   pixel_type             s1_pix_ff;
   logic [SLOT_COUNT-1:0] s1_mask_ff;
   logic                  s1_int_ff;

   // both line buffers share one word: older row high, newer row low
   logic [47:0] lb_mem [MAX_WIDTH];
   logic [47:0] rd_ff, wb_ff, line1;
   pixel_type   top1, mid1;

   assign line1 = fwd_ff ? wb_ff : rd_ff;
   assign top1  = line1[47:24];
   assign mid1  = line1[23:0];

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= lb_mem[x_cur];
      end
      if (s1_v_ff) begin
         lb_mem[s1_x_ff] <= {mid1, s1_pix_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         fwd_ff  <= 1'b0;
      end else begin
         s1_v_ff <= accept;
         // same address written back this cycle: the read sees stale data
         fwd_ff  <= accept && s1_v_ff && (x_cur == s1_x_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_x_ff    <= x_cur;
         s1_pix_ff  <= pix0;
         s1_mask_ff <= mask0;
         s1_int_ff  <= interior;
      end
      if (s1_v_ff) begin
         wb_ff <= {mid1, s1_pix_ff};
      end
   end

   // window of the two previous columns
   pixel_type wc_ff [6];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            wc_ff[i] <= '0;
         end
      end else if (s1_v_ff) begin
         wc_ff[0] <= wc_ff[3];
         wc_ff[1] <= wc_ff[4];
         wc_ff[2] <= wc_ff[5];
         wc_ff[3] <= top1;
         wc_ff[4] <= mid1;
         wc_ff[5] <= s1_pix_ff;
      end
   end

   // stage 2: full 3x3 window, kernel
   logic                  s2_v_ff;
   pixel_type             s2_win_ff [9];
   logic [SLOT_COUNT-1:0] s2_mask_ff;
   logic                  s2_int_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_v_ff) begin
         for (int i = 0; i < 6; i++) begin
            s2_win_ff[i] <= wc_ff[i];
         end
         s2_win_ff[6] <= top1;
         s2_win_ff[7] <= mid1;
         s2_win_ff[8] <= s1_pix_ff;
         s2_mask_ff   <= s1_mask_ff;
         s2_int_ff    <= s1_int_ff;
      end
   end

   pixel_type sobel_val;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sobel_val[8*c +: 8] = sobel_chan(s2_win_ff[0][8*c +: 8], s2_win_ff[1][8*c +: 8],
                                          s2_win_ff[2][8*c +: 8], s2_win_ff[3][8*c +: 8],
                                          s2_win_ff[5][8*c +: 8], s2_win_ff[6][8*c +: 8],
                                          s2_win_ff[7][8*c +: 8], s2_win_ff[8][8*c +: 8]);
      end
   end

   assign job_valid      = s2_v_ff && (s2_mask_ff != '0);
   assign job.mask       = s2_mask_ff;
   assign job.value      = s2_int_ff ? sobel_val : '0;
   assign status.s1_busy = s1_v_ff;
   assign status.s2_busy = s2_v_ff;

endmodule

// ===== design/sem_job_queue.sv =====
module sem_job_queue
   import sem_pkg::*;
#(
   parameter int DEPTH = JOB_QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  job_type                    push_job,
   input  logic                       pop,
   output logic                       head_valid,
   output job_type                    head_job,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   job_type       entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          do_pop;

   assign do_pop     = pop && (count_ff != '0);
   assign head_valid = count_ff != '0;
   assign head_job   = entry_ff[rd_ptr_ff];
   assign count      = count_ff;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (!push && do_pop) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

endmodule

// ===== design/sem_back.sv =====
module sem_back
   import sem_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            job_valid,
   input  job_type         job,
   output logic            job_pop,
   output logic            rsp_empty,
   input  logic            rsp_pop,
   output rsp_payload_type rsp_data
);

   logic                  cur_v_ff;
   logic [SLOT_COUNT-1:0] cur_mask_ff, mask_next, low_bit;
   pixel_type             cur_val_ff, emit_val;
   logic                  out_v_ff;
   rsp_payload_type       out_ff;
   logic                  can_load, emit, done, take;

   assign can_load  = !out_v_ff || rsp_pop;
   assign emit      = cur_v_ff && can_load;
   assign low_bit   = cur_mask_ff & (~cur_mask_ff + SLOT_COUNT'(1));
   assign mask_next = cur_mask_ff & ~low_bit;
   assign done      = mask_next == '0;
   assign take      = !cur_v_ff || (emit && done);
   assign job_pop   = take && job_valid;
   // only the center result carries the kernel value
   assign emit_val  = low_bit[SLOT_CENTER] ? cur_val_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_v_ff <= 1'b0;
      end else if (job_pop) begin
         cur_v_ff <= 1'b1;
      end else if (emit && done) begin
         cur_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         cur_mask_ff <= job.mask;
         cur_val_ff  <= job.value;
      end else if (emit) begin
         cur_mask_ff <= mask_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (emit) begin
         out_v_ff <= 1'b1;
      end else if (rsp_pop) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_ff.blue_out   <= emit_val[7:0];
         out_ff.green_out  <= emit_val[15:8];
         out_ff.red_out    <= emit_val[23:16];
         out_ff.frame_last <= low_bit[SLOT_LAST_END];
      end
   end

   assign rsp_empty = !out_v_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== dv/sobel_edge_magnitude_3x3_tb.sv =====
`timescale 1ns / 1ps

module sobel_edge_magnitude_3x3_tb;
   import sem_pkg::*;

   localparam int MAX_W         = MAX_WIDTH_DEFAULT;
   localparam int RANDOM_ITEMS  = 480;
   // a pixel can be in flight with nothing owed yet
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES   = 600;
   localparam int LIMIT_NS      = 5_000_000;

   // one directed pixel, with the results typed in where they are obvious
   typedef struct packed {
      req_payload_type       px;
      logic                  typed;
      logic [2:0]            count;
      rsp_payload_type [0:3] res;
   } stim_row_type;

   localparam rsp_payload_type ZR = '{8'd0, 8'd0, 8'd0, 1'b0};
   localparam rsp_payload_type LR = '{8'd0, 8'd0, 8'd0, 1'b1};
   localparam rsp_payload_type [0:3] NO_EDGES  = '{ZR, ZR, ZR, ZR};
   localparam rsp_payload_type [0:3] LAST_FOUR = '{ZR, ZR, ZR, LR};
   localparam req_payload_type WHITE_FIRST = '{1'b1, 8'd255, 8'd255, 8'd255};
   localparam req_payload_type WHITE       = '{1'b0, 8'd255, 8'd255, 8'd255};

   // two 3x3 frames: a flat white one where every output is zero, then one whose
   // center saturates on blue and green and lands mid-range on red. the second
   // frame starts without frame_start, relying on the counters wrapping
   localparam stim_row_type DIRECTED_ROWS [18] = '{
      '{WHITE_FIRST, 1'b1, 3'd0, NO_EDGES},
      '{WHITE,       1'b1, 3'd0, NO_EDGES},
      '{WHITE,       1'b1, 3'd0, NO_EDGES},
      '{WHITE,       1'b1, 3'd0, NO_EDGES},
      '{WHITE,       1'b1, 3'd1, NO_EDGES},
      '{WHITE,       1'b1, 3'd2, NO_EDGES},
      '{WHITE,       1'b1, 3'd0, NO_EDGES},
      '{WHITE,       1'b1, 3'd2, NO_EDGES},
      '{WHITE,       1'b1, 3'd4, LAST_FOUR},
      '{'{1'b0, 8'd0,   8'd255, 8'd0},   1'b0, 3'd0, NO_EDGES},
      '{'{1'b0, 8'd0,   8'd255, 8'd255}, 1'b0, 3'd0, NO_EDGES},
      '{'{1'b0, 8'd255, 8'd255, 8'd0},   1'b0, 3'd0, NO_EDGES},
      '{'{1'b0, 8'd0,   8'd255, 8'd0},   1'b0, 3'd0, NO_EDGES},
      '{'{1'b0, 8'd0,   8'd0,   8'd0},   1'b0, 3'd0, NO_EDGES},
      '{'{1'b0, 8'd255, 8'd0,   8'd0},   1'b0, 3'd0, NO_EDGES},
      '{'{1'b0, 8'd255, 8'd255, 8'd0},   1'b0, 3'd0, NO_EDGES},
      '{'{1'b0, 8'd255, 8'd0,   8'd0},   1'b0, 3'd0, NO_EDGES},
      '{'{1'b0, 8'd255, 8'd0,   8'd0},   1'b0, 3'd0, NO_EDGES}
   };

   // dut ports, the ones the bench drives known from time zero
   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_push  = 1'b0;
   logic                  req_full;
   req_payload_type       req_data  = '0;
   logic                  rsp_empty;
   logic                  rsp_pop   = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  csr_write = 1'b0;
   logic [0:0]            csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state: two line stores, two window columns, position and geometry
   pixel_type              top_line [MAX_W];
   pixel_type              mid_line [MAX_W];
   pixel_type              left_cols [6] = '{default: '0};
   int unsigned            cur_col = 0;
   int unsigned            cur_row = 0;
   logic [CFG_WIDTH_W-1:0]  width_csr  = WIDTH_RESET;
   logic [CFG_HEIGHT_W-1:0] height_csr = HEIGHT_RESET;

   rsp_payload_type expected_edges [$];
   int              error_count = 0;

   // sender burst state, the receiver's stall modes and its one-time hold-off
   int   burst_left   = 0;
   logic hold_request = 1'b0;
   logic hold_done    = 1'b0;
   int   hold_left    = 0;
   int   pop_mode     = 0;
   int   mode_left    = 0;
   int   pop_tick     = 0;

   sobel_edge_magnitude_3x3 uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // register values as the block uses them: width clamped both ways, height from below
   function automatic int unsigned active_width();
      int unsigned w;
      w = width_csr;
      if (w < 3) w = 3;
      if (w > MAX_W) w = MAX_W;
      return w;
   endfunction

   function automatic int unsigned active_height();
      int unsigned h;
      h = height_csr;
      if (h < 3) h = 3;
      return h;
   endfunction

   // nb[col*3+row], columns left to right, rows top to bottom
   function automatic pixel_type sobel_value(input pixel_type [8:0] nb);
      pixel_type v;
      int        c, t0, m0, b0, t1, b1, t2, m2, b2, gx, gy, mag;
      v = '0;
      for (c = 0; c < 3; c++) begin
         t0 = int'(nb[0][8*c +: 8]);
         m0 = int'(nb[1][8*c +: 8]);
         b0 = int'(nb[2][8*c +: 8]);
         t1 = int'(nb[3][8*c +: 8]);
         b1 = int'(nb[5][8*c +: 8]);
         t2 = int'(nb[6][8*c +: 8]);
         m2 = int'(nb[7][8*c +: 8]);
         b2 = int'(nb[8][8*c +: 8]);
         gy = (b0 + 2 * b1 + b2) - (t0 + 2 * t1 + t2);
         gx = (t2 + 2 * m2 + b2) - (t0 + 2 * m0 + b0);
         if (gx < 0) gx = -gx;
         if (gy < 0) gy = -gy;
         mag = (gx + gy) / 4;
         if (mag > 255) mag = 255;
         v[8*c +: 8] = mag[7:0];
      end
      return v;
   endfunction

   function automatic rsp_payload_type to_result(input pixel_type v, input logic last);
      rsp_payload_type r;
      r.blue_out   = v[7:0];
      r.green_out  = v[15:8];
      r.red_out    = v[23:16];
      r.frame_last = last;
      return r;
   endfunction

   // advances the predictor by one pixel and returns the results it owes
   function automatic void predict_edges(input req_payload_type px, output int n,
                                         output rsp_payload_type [0:3] res);
      int unsigned     w, h, x, y;
      pixel_type       pix, top, mid, v;
      pixel_type [8:0] nb;
      logic            row_end, last_row;
      n   = 0;
      res = '0;
      w   = active_width();
      h   = active_height();
      if (px.frame_start) begin
         cur_col = 0;
         cur_row = 0;
      end
      x   = cur_col;
      y   = cur_row;
      pix = {px.red_in, px.green_in, px.blue_in};
      top = '0;
      mid = '0;
      if (x < MAX_W) begin
         top = top_line[x];
         mid = mid_line[x];
      end
      for (int k = 0; k < 6; k++) nb[k] = left_cols[k];
      nb[6] = top;
      nb[7] = mid;
      nb[8] = pix;
      row_end  = (x >= w - 1);
      last_row = (y >= h - 1);

      // center output one row up and one column left, then the row-end border pixel,
      // then on the last row the bottom border pixels, the very last one flagged
      if (y >= 1) begin
         if (x >= 1) begin
            v = '0;
            if (y >= 2 && x >= 2 && x <= w - 1 && y - 1 <= h - 2) v = sobel_value(nb);
            res[n] = to_result(v, 1'b0);
            n++;
         end
         if (row_end) begin
            res[n] = to_result('0, 1'b0);
            n++;
         end
         if (last_row) begin
            if (x >= 1) begin
               res[n] = to_result('0, 1'b0);
               n++;
            end
            if (row_end) begin
               res[n] = to_result('0, 1'b1);
               n++;
            end
         end
      end

      if (x < MAX_W) begin
         top_line[x] = mid;
         mid_line[x] = pix;
      end
      left_cols[0] = left_cols[3];
      left_cols[1] = left_cols[4];
      left_cols[2] = left_cols[5];
      left_cols[3] = top;
      left_cols[4] = mid;
      left_cols[5] = pix;

      if (row_end) begin
         cur_col = 0;
         cur_row = last_row ? 0 : (y + 1) & 32'hFFFF;
      end else begin
         cur_col = (x + 1) & 32'h1FFF;
      end
   endfunction

   // offers one pixel in bursts with random gaps; push stays high across a burst.
   // on transfer the owed results are queued, typed ones taken from the table
   task automatic send_pixel(input req_payload_type px, input logic typed,
                             input logic [2:0] count, input rsp_payload_type [0:3] typed_res);
      int                    n, gap;
      rsp_payload_type [0:3] res;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 256)
                                                  : $urandom_range(1, 24);
         if (gap != 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_push <= 1'b1;
      req_data <= px;
      do @(posedge clock); while (req_full);
      predict_edges(px, n, res);
      if (typed) begin
         n   = count;
         res = typed_res;
      end
      for (int k = 0; k < n; k++) expected_edges.push_back(res[k]);
   endtask

   // block is idle once nothing is owed and the pipeline has had time to empty
   task automatic wait_quiet();
      req_push <= 1'b0;
      while (expected_edges.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_geometry(input logic [CSR_DATA_W-1:0] wdata,
                               input logic [CSR_DATA_W-1:0] hdata);
      wait_quiet();
      csr_write <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= wdata;
      @(posedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= hdata;
      @(posedge clock);
      csr_write  <= 1'b0;
      width_csr  = wdata[CFG_WIDTH_W-1:0];
      height_csr = hdata[CFG_HEIGHT_W-1:0];
   endtask

   // raster pixels of the current geometry; stop_len short of w*h leaves a broken frame,
   // and the next frame then has to restart the counters with frame_start
   task automatic send_frame(input int stop_len);
      req_payload_type px;
      int              shade;
      logic [7:0]      base;
      shade = $urandom_range(0, 3);
      base  = 8'($urandom);
      for (int k = 0; k < stop_len; k++) begin
         if (k == 0)
            px.frame_start = (cur_col == 0 && cur_row == 0) ? ($urandom_range(0, 3) != 0)
                                                             : 1'b1;
         else
            px.frame_start = 1'b0;
         case (shade)
            1: begin
               // hard edges, all-zero and all-one channel values
               px.blue_in  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               px.green_in = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               px.red_in   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            2: begin
               // nearly flat, small gradients off saturation unless a value wraps past 255
               px.blue_in  = base + 8'($urandom_range(0, 7));
               px.green_in = base + 8'($urandom_range(0, 7));
               px.red_in   = base + 8'($urandom_range(0, 7));
            end
            default: begin
               px.blue_in  = 8'($urandom);
               px.green_in = 8'($urandom);
               px.red_in   = 8'($urandom);
            end
         endcase
         send_pixel(px, 1'b0, 3'd0, NO_EDGES);
      end
   endtask

   task automatic check_edge(input rsp_payload_type got);
      rsp_payload_type want;
      if (expected_edges.size() == 0) begin
         $error("result transfer with nothing expected: %h", got);
         error_count++;
      end else begin
         want = expected_edges.pop_front();
         if (got.blue_out !== want.blue_out) begin
            $error("blue_out expected %0d actual %0d", want.blue_out, got.blue_out);
            error_count++;
         end
         if (got.green_out !== want.green_out) begin
            $error("green_out expected %0d actual %0d", want.green_out, got.green_out);
            error_count++;
         end
         if (got.red_out !== want.red_out) begin
            $error("red_out expected %0d actual %0d", want.red_out, got.red_out);
            error_count++;
         end
         if (got.frame_last !== want.frame_last) begin
            $error("frame_last expected %0d actual %0d", want.frame_last, got.frame_last);
            error_count++;
         end
      end
   endtask

   // receiver: checks each transfer, then picks pop for the next edge. it runs through
   // stall modes of its own and, once asked, holds off for a long counted stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) check_edge(rsp_data);
         pop_tick++;
         if (hold_left != 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_pop <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               pop_mode  = $urandom_range(0, 3);
               mode_left = $urandom_range(16, 96);
            end else begin
               mode_left--;
            end
            case (pop_mode)
               0:       rsp_pop <= 1'b1;
               1:       rsp_pop <= 1'($urandom_range(0, 1));
               2:       rsp_pop <= ($urandom_range(0, 9) != 0);
               default: rsp_pop <= (pop_tick % 4 == 0);
            endcase
         end
      end
   end

   initial begin
      int random_items;
      int phase;
      int pick;
      int frame_len;
      random_items = 0;
      phase        = 0;
      // line stores start unknown in the block; the predictor keeps them at zero
      for (int i = 0; i < MAX_W; i++) begin
         top_line[i] = '0;
         mid_line[i] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed part on the smallest frame
      set_geometry(16'd3, 16'd3);
      foreach (DIRECTED_ROWS[i])
         send_pixel(DIRECTED_ROWS[i].px, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].count,
                    DIRECTED_ROWS[i].res);

      // random frames, mostly small and well formed, some cut short
      while (random_items < RANDOM_ITEMS) begin
         case (phase)
            2: begin
               // upper register bits are ignored, height below range clamps to 3.
               // the receiver holds off here so the block fills and stalls its input
               set_geometry({4'($urandom), 12'($urandom_range(8, 12))},
                            16'($urandom_range(0, 2)));
               hold_request <= 1'b1;
               frame_len = active_width() * active_height();
               send_frame(frame_len);
               random_items += frame_len;
            end
            5: begin
               // tallest frame: only a few rows, the next frame restarts the counters
               set_geometry(16'($urandom_range(3, 9)), 16'hFFFF);
               frame_len = active_width() * $urandom_range(2, 4) + $urandom_range(0, 2);
               send_frame(frame_len);
               random_items += frame_len;
            end
            default: begin
               pick = $urandom_range(0, 9);
               if (pick == 0 && active_width() * active_height() > 200) pick = 3;
               case (pick)
                  0: ;
                  1: set_geometry({4'($urandom), 12'($urandom_range(0, 2))},
                                  16'($urandom_range(3, 6)));
                  2: set_geometry(16'($urandom_range(3, 12)), 16'($urandom_range(0, 2)));
                  default: set_geometry(16'($urandom_range(3, 12)),
                                        16'($urandom_range(3, 6)));
               endcase
               frame_len = active_width() * active_height();
               if ($urandom_range(0, 5) == 0) frame_len = $urandom_range(1, frame_len - 1);
               send_frame(frame_len);
               random_items += frame_len;
            end
         endcase
         phase++;
      end

      wait_quiet();
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // watchdog
   initial begin
      #(LIMIT_NS);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
